>>> hw/rtl/pidc_pkg.sv
// Package for the clamped PID controller: sizes, register indexes,
// configuration bundle type and the limit clamp function.
// No dependencies.
`timescale 1ns / 1ps

package pidc_pkg;

  // Sample and gain formats
  localparam int SAMPLE_WIDTH   = 16;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_BITS      = 24;

  // Configuration port sizes
  localparam int CFG_COUNT  = 5;
  localparam int CFG_IDX_W  = $clog2(CFG_COUNT);
  localparam int CFG_DATA_W = (GAIN_BITS > SAMPLE_WIDTH) ? GAIN_BITS : SAMPLE_WIDTH;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CV_HIGH = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_CV_LOW  = CFG_IDX_W'(4);

  // Datapath widths
  localparam int ERR_W  = SAMPLE_WIDTH + 1;      // setpoint minus process value
  localparam int DERR_W = SAMPLE_WIDTH + 2;      // change in error
  localparam int PROD_W = GAIN_BITS + DERR_W;    // widest gain product
  localparam int PD_W   = PROD_W + 1;            // P plus D at full precision
  localparam int RND_W  = PD_W - GAIN_FRAC_BITS; // after rounding to integer
  localparam int SUM_W  = RND_W + 1;             // rounded term plus integral

  // Reset limits: full sample range
  localparam logic signed [SAMPLE_WIDTH-1:0] CV_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] CV_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [GAIN_BITS-1:0]    gain_t;

  // Configuration bundle from the register file to the datapath
  typedef struct packed {
    gain_t   kp_gain;
    gain_t   ki_gain;
    gain_t   kd_gain;
    sample_t cv_high;
    sample_t cv_low;
  } pidc_cfg_t;

  // Clamp to [lo, hi]; inverted limits give lo
  function automatic sample_t clamp_limits(logic signed [SUM_W-1:0] x,
                                           sample_t lo, sample_t hi);
    logic signed [SUM_W-1:0] lo_x;
    logic signed [SUM_W-1:0] hi_x;
    sample_t                 res;
    lo_x = SUM_W'(lo);
    hi_x = SUM_W'(hi);
    if (lo > hi) begin
      res = lo;
    end else if (x < lo_x) begin
      res = lo;
    end else if (x > hi_x) begin
      res = hi;
    end else begin
      res = x[SAMPLE_WIDTH-1:0];
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/pidc_if.sv
// Valid/ready channel interfaces for the PID controller sample and result beats.
// Depends on pidc_pkg.
`timescale 1ns / 1ps

interface pidc_in_if;
  import pidc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t process_value;
  sample_t setpoint;

  modport source (output valid, output process_value, output setpoint, input ready);
  modport sink   (input valid, input process_value, input setpoint, output ready);
endinterface

interface pidc_out_if;
  import pidc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t control_value;

  modport source (output valid, output control_value, input ready);
  modport sink   (input valid, input control_value, output ready);
endinterface

>>> hw/rtl/pidc_cfg_regs.sv
// Configuration register file for the PID controller: gains and clamp limits.
// Depends on pidc_pkg.
`timescale 1ns / 1ps

module pidc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output pidc_pkg::pidc_cfg_t                cfg
);
  import pidc_pkg::*;

  pidc_cfg_t cfg_r;
  pidc_cfg_t cfg_nxt;

  // Decode the write into the addressed register; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_KP_GAIN: cfg_nxt.kp_gain = cfg_wdata[GAIN_BITS-1:0];
        REG_KI_GAIN: cfg_nxt.ki_gain = cfg_wdata[GAIN_BITS-1:0];
        REG_KD_GAIN: cfg_nxt.kd_gain = cfg_wdata[GAIN_BITS-1:0];
        REG_CV_HIGH: cfg_nxt.cv_high = cfg_wdata[SAMPLE_WIDTH-1:0];
        REG_CV_LOW:  cfg_nxt.cv_low  = cfg_wdata[SAMPLE_WIDTH-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain <= '0;
      cfg_r.ki_gain <= '0;
      cfg_r.kd_gain <= '0;
      cfg_r.cv_high <= CV_MAX;
      cfg_r.cv_low  <= CV_MIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/pidc_core.sv
// PID datapath: error, integral with clamp, P plus D with rounding, output clamp.
// Holds the integral and previous error. Depends on pidc_pkg.
`timescale 1ns / 1ps

module pidc_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  pidc_pkg::sample_t     process_value,
  input  pidc_pkg::sample_t     setpoint,
  input  pidc_pkg::pidc_cfg_t   cfg,
  output pidc_pkg::sample_t     control_value
);
  import pidc_pkg::*;

  localparam logic signed [PD_W-1:0] HALF = PD_W'(1) <<< (GAIN_FRAC_BITS - 1);

  sample_t                          integral_r;
  sample_t                          integral_nxt;
  logic signed [ERR_W-1:0]          prev_err_r;

  logic signed [ERR_W-1:0]          err;
  logic signed [DERR_W-1:0]         derr;
  logic signed [GAIN_BITS+ERR_W-1:0]  p_prod;
  logic signed [GAIN_BITS+ERR_W-1:0]  i_prod;
  logic signed [GAIN_BITS+DERR_W-1:0] d_prod;
  logic signed [PD_W-1:0]           pd_half;
  logic signed [PD_W-1:0]           i_half;
  logic signed [RND_W-1:0]          pd_rnd;
  logic signed [RND_W-1:0]          i_rnd;
  logic signed [SUM_W-1:0]          i_sum;
  logic signed [SUM_W-1:0]          cv_sum;

  // Error and its change since the last sample
  assign err  = ERR_W'(setpoint) - ERR_W'(process_value);
  assign derr = DERR_W'(err) - DERR_W'(prev_err_r);

  // Gain products
  assign p_prod = cfg.kp_gain * err;
  assign i_prod = cfg.ki_gain * err;
  assign d_prod = cfg.kd_gain * derr;

  // Round half up to integer
  assign i_half  = PD_W'(i_prod) + HALF;
  assign pd_half = PD_W'(p_prod) + PD_W'(d_prod) + HALF;
  assign i_rnd   = i_half[PD_W-1:GAIN_FRAC_BITS];
  assign pd_rnd  = pd_half[PD_W-1:GAIN_FRAC_BITS];

  // Integrate, clamp, then form the output
  assign i_sum         = SUM_W'(integral_r) + SUM_W'(i_rnd);
  assign integral_nxt  = clamp_limits(i_sum, cfg.cv_low, cfg.cv_high);
  assign cv_sum        = SUM_W'(pd_rnd) + SUM_W'(integral_nxt);
  assign control_value = clamp_limits(cv_sum, cfg.cv_low, cfg.cv_high);

  // Advance the controller state once per sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      prev_err_r <= '0;
    end else if (step) begin
      integral_r <= integral_nxt;
      prev_err_r <= err;
    end
  end

endmodule

>>> hw/rtl/pid_controller_clamped_top.sv
// Top level of the clamped PID controller: sample register, datapath, result register.
// Depends on pidc_pkg, pidc_if, pidc_cfg_regs and pidc_core.
//
// Usage:
//   in_if  : sample beats (process_value, setpoint), valid/ready.
//   out_if : result beats (control_value), valid/ready, one per sample.
//   cfg_*  : write port for kp_gain, ki_gain, kd_gain, cv_high, cv_low
//            (indexes 0 to 4); write only while no sample is in flight.
// Stages: a sample accepted into the sample register moves on into the
//   result register when that is free, two register stages in all.
// Throughput: one sample per cycle while out_if.ready stays high, set by
//   the integral update loop in the datapath (multiply, round, add, clamp).
// Reset (rst_n low, synchronous): both stages empty, integral and
//   previous error zero, gains zero, limits at the full sample range.
// Stall: while out_if.ready is low the result holds, the sample stage
//   still takes one beat, and in_if.ready drops once it is full.
`timescale 1ns / 1ps

module pid_controller_clamped_top (
  input  logic                            clk,
  input  logic                            rst_n,
  pidc_in_if.sink                         in_if,
  pidc_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pidc_pkg::*;

  pidc_cfg_t cfg;

  logic    s1_valid_r;
  logic    s1_valid_nxt;
  sample_t s1_pv_r;
  sample_t s1_sp_r;
  logic    out_valid_r;
  logic    out_valid_nxt;
  sample_t out_cv_r;
  sample_t cv_nxt;
  logic    in_fire;
  logic    adv;

  pidc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pidc_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (adv),
    .process_value (s1_pv_r),
    .setpoint      (s1_sp_r),
    .cfg           (cfg),
    .control_value (cv_nxt)
  );

  // Handshake: advance the sample into the result register when it is free
  assign adv         = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || adv;
  assign in_fire     = in_if.valid && in_if.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold the control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the sample beat and the result beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pv_r <= in_if.process_value;
      s1_sp_r <= in_if.setpoint;
    end
    if (adv) begin
      out_cv_r <= cv_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.control_value = out_cv_r;

endmodule

>>> test/tb.sv
// Self-checking testbench for the clamped PID controller top level.
// Depends on pidc_pkg, pidc_if and pid_controller_clamped_top; drives valid/ready beats and register writes.
`timescale 1ns / 1ps

module tb;
  import pidc_pkg::*;

  localparam int    IDLE_LIMIT = 500;
  localparam int    PHASES     = 15;
  localparam int    PHASE_LEN  = 100;
  localparam gain_t GAIN_MAX   = {1'b0, {(GAIN_BITS-1){1'b1}}};
  localparam gain_t GAIN_MIN   = {1'b1, {(GAIN_BITS-1){1'b0}}};

  // Tracks controller state and the control values still owed by the block
  class pid_tracker;
    gain_t                   kp, ki, kd;
    sample_t                 cv_hi, cv_lo;
    sample_t                 integ;
    logic signed [ERR_W-1:0] prev_err;
    sample_t                 pending_cv[$];
    int                      errors;
    int                      checked;

    function new();
      kp = '0; ki = '0; kd = '0;
      cv_hi = CV_MAX; cv_lo = CV_MIN;
      integ = '0; prev_err = '0;
      errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_KP_GAIN: kp = data[GAIN_BITS-1:0];
        REG_KI_GAIN: ki = data[GAIN_BITS-1:0];
        REG_KD_GAIN: kd = data[GAIN_BITS-1:0];
        REG_CV_HIGH: cv_hi = data[SAMPLE_WIDTH-1:0];
        REG_CV_LOW:  cv_lo = data[SAMPLE_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // Inverted limits always give the lower limit
    function sample_t limit(longint x);
      if (cv_lo > cv_hi) return cv_lo;
      if (x < longint'(cv_lo)) return cv_lo;
      if (x > longint'(cv_hi)) return cv_hi;
      return sample_t'(x);
    endfunction

    // Round half up from the gain fraction to an integer
    function longint to_integer(longint x);
      return (x + (longint'(1) <<< (GAIN_FRAC_BITS-1))) >>> GAIN_FRAC_BITS;
    endfunction

    function void take_sample(sample_t pv, sample_t sp);
      longint err;
      longint pd;
      err   = longint'(sp) - longint'(pv);
      integ = limit(longint'(integ) + to_integer(longint'(ki) * err));
      pd    = longint'(kp) * err + longint'(kd) * (err - longint'(prev_err));
      pending_cv.push_back(limit(to_integer(pd) + longint'(integ)));
      prev_err = err[ERR_W-1:0];
    endfunction

    function void match_control(sample_t cv);
      sample_t want;
      if (pending_cv.size() == 0) begin
        errors++;
        $display("%0t: control_value expected none, got %0d", $time, cv);
      end else begin
        want = pending_cv.pop_front();
        checked++;
        if (cv !== want) begin
          errors++;
          $display("%0t: control_value expected %0d, got %0d", $time, want, cv);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  calm;
  int                    idle_cycles;
  int                    samples_sent;
  int                    settings_done;
  sample_t               target;
  pid_tracker            sb;

  pidc_in_if  in_ch ();
  pidc_out_if out_ch ();

  pid_controller_clamped_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial sb = new();

  // Observe accepted beats on both channels and guard against a hang
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.take_sample(in_ch.process_value, in_ch.setpoint);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.match_control(out_ch.control_value);
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each beat
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Offer one sample beat after a random gap; hold until taken
  task automatic send_sample(sample_t pv, sample_t sp);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.process_value <= pv;
    in_ch.setpoint      <= sp;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
  endtask

  // Hold off the sender until every result is back, then let the pipe settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_cv.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic cfg_done();
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_done++;
  endtask

  task automatic program_all(gain_t kp, gain_t ki, gain_t kd, sample_t hi, sample_t lo);
    cfg_write(REG_KP_GAIN, CFG_DATA_W'(kp));
    cfg_write(REG_KI_GAIN, CFG_DATA_W'(ki));
    cfg_write(REG_KD_GAIN, CFG_DATA_W'(kd));
    cfg_write(REG_CV_HIGH, CFG_DATA_W'(hi));
    cfg_write(REG_CV_LOW,  CFG_DATA_W'(lo));
    cfg_done();
  endtask

  function automatic gain_t pick_gain();
    case ($urandom_range(0, 5))
      0:       return GAIN_MIN;
      1:       return GAIN_MAX;
      2:       return '0;
      3:       return gain_t'($urandom);
      default: return gain_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  // Random register setting; some registers keep their old value
  task automatic random_setting(bit all_regs);
    int      a, b;
    sample_t hi, lo;
    case ($urandom_range(0, 5))
      0: begin hi = CV_MAX; lo = CV_MIN; end
      1: begin
        a  = $urandom_range(0, 32767);
        hi = sample_t'(a - 32768);
        lo = sample_t'($urandom_range(a, 65535) - 32767);
      end
      2: begin hi = sample_t'($urandom); lo = hi; end
      3: begin
        a  = int'($urandom_range(0, 4000)) - 2000;
        b  = int'($urandom_range(0, 4000)) - 2000;
        hi = sample_t'((a > b) ? a : b);
        lo = sample_t'((a > b) ? b : a);
      end
      default: begin
        a  = int'($urandom_range(0, 65535)) - 32768;
        b  = int'($urandom_range(0, 65535)) - 32768;
        hi = sample_t'((a > b) ? a : b);
        lo = sample_t'((a > b) ? b : a);
      end
    endcase
    if (all_regs || $urandom_range(0, 3) != 0) cfg_write(REG_KP_GAIN, CFG_DATA_W'(pick_gain()));
    if (all_regs || $urandom_range(0, 3) != 0) cfg_write(REG_KI_GAIN, CFG_DATA_W'(pick_gain()));
    if (all_regs || $urandom_range(0, 3) != 0) cfg_write(REG_KD_GAIN, CFG_DATA_W'(pick_gain()));
    if (all_regs || $urandom_range(0, 3) != 0) cfg_write(REG_CV_HIGH, CFG_DATA_W'(hi));
    if (all_regs || $urandom_range(0, 3) != 0) cfg_write(REG_CV_LOW,  CFG_DATA_W'(lo));
    // Writes past the last register must leave the setting alone
    if ($urandom_range(0, 3) == 0) begin
      cfg_write(CFG_IDX_W'($urandom_range(CFG_COUNT, (1 << CFG_IDX_W) - 1)),
                CFG_DATA_W'($urandom));
    end
    cfg_done();
  endtask

  // Mostly a process tracking a slowly stepping target, with some wild beats
  task automatic random_sample();
    int      pv;
    sample_t picks[5];
    picks = '{CV_MIN, CV_MAX, sample_t'(0), sample_t'(-1), sample_t'(1)};
    if ($urandom_range(0, 19) == 0) target = sample_t'($urandom);
    case ($urandom_range(0, 7))
      0: send_sample(sample_t'($urandom), sample_t'($urandom));
      1: send_sample(picks[$urandom_range(0, 4)], picks[$urandom_range(0, 4)]);
      default: begin
        pv = int'(target) + int'($urandom_range(0, 1024)) - 512;
        if (pv > 32767) pv = 32767;
        if (pv < -32768) pv = -32768;
        send_sample(sample_t'(pv), target);
      end
    endcase
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.process_value <= '0;
    in_ch.setpoint      <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_KP_GAIN;
    cfg_wdata           <= '0;
    calm                 = 1'b0;
    idle_cycles         <= 0;
    samples_sent         = 0;
    settings_done        = 0;
    target               = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: zero gains, full limits
    send_sample(16'sd0, 16'sd0);
    send_sample(CV_MIN, CV_MAX);
    send_sample(CV_MAX, CV_MIN);
    send_sample(16'sd123, -16'sd456);
    drain();

    // Half gain: rounding of plus and minus one half
    program_all(gain_t'(24'h008000), '0, '0, CV_MAX, CV_MIN);
    send_sample(16'sd0, 16'sd1);
    send_sample(16'sd0, -16'sd1);
    send_sample(16'sd0, 16'sd3);
    send_sample(16'sd0, -16'sd3);
    drain();

    // Integral winds up against narrow limits and back
    program_all(gain_t'(24'h010000), gain_t'(24'h004000), gain_t'(24'h020000),
                16'sd1000, -16'sd1000);
    repeat (3) send_sample(16'sd0, CV_MAX);
    repeat (2) send_sample(16'sd0, CV_MIN);
    send_sample(16'sd5, 16'sd5);
    drain();

    // Zero integral gain: accumulator only re-clamped to tighter limits
    program_all('0, '0, '0, 16'sd10, -16'sd10);
    send_sample(16'sd7, 16'sd7);
    send_sample(CV_MIN, CV_MAX);
    drain();

    // Inverted limits with extreme gains
    program_all(GAIN_MAX, GAIN_MIN, GAIN_MAX, -16'sd100, 16'sd100);
    send_sample(CV_MIN, CV_MAX);
    send_sample(CV_MAX, CV_MIN);
    send_sample(16'sd0, 16'sd0);
    drain();

    // Opposite extreme gains, full limits, then stray register indexes
    program_all(GAIN_MIN, GAIN_MAX, GAIN_MIN, CV_MAX, CV_MIN);
    cfg_write(CFG_IDX_W'(CFG_COUNT), '1);
    cfg_write('1, '0);
    cfg_done();
    send_sample(CV_MAX, CV_MIN);
    send_sample(CV_MIN, CV_MAX);
    send_sample(16'sd1, -16'sd1);
    drain();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      random_setting(ph == 0);
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_LEN; k++) begin
        if (k == PHASE_LEN / 2 && (ph == 0 || $urandom_range(0, 2) == 0)) drain();
        random_sample();
      end
      drain();
    end

    $display("Covered %0d sample beats under %0d register settings, %0d results compared.",
             samples_sent, settings_done, sb.checked);
    if (sb.errors == 0 && sb.pending_cv.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/pidc_pkg.sv
hw/rtl/pidc_if.sv
hw/rtl/pidc_cfg_regs.sv
hw/rtl/pidc_core.sv
hw/rtl/pid_controller_clamped_top.sv
test/tb.sv
